// ===== hdl/gbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy box suppression package
// Shared types and fixed constants for the suppression block and its
// overlap compare pipeline.
// ----------------------------------------------------------------------------
package gbs_pkg;

    // Field widths that the box format fixes.
    localparam int COORD_W = 16;
    localparam int AREA_W  = 32;
    localparam int THR_W   = 9;
    localparam int NUM_W   = 12;

    // Largest box number the output field can carry.
    localparam logic [NUM_W-1:0] NUM_MAX = 12'd4095;

    // Threshold after reset: 0.5 in Q1.8.
    localparam logic [THR_W-1:0] THR_RESET = 9'd128;

    // One box in unsigned Q12.4, packed as it sits in the store.
    typedef struct packed {
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_box;

    // Status from the compare pipeline to the sequencer.
    typedef struct packed {
        logic busy;
        logic valid;
        logic hit;
    } t_cmp;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

// ===== hdl/gbs_iou.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overlap compare pipeline
// Compares the current box against one stored box per cycle and flags
// intersection * 256 > threshold * union, in four register stages.
// ----------------------------------------------------------------------------
module gbs_iou
    import gbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_valid,
    input  t_box              i_cand,
    input  logic [AREA_W-1:0] i_cand_area,
    input  t_box              i_kept,
    input  logic [AREA_W-1:0] i_kept_area,
    input  logic [THR_W-1:0]  i_thr,
    output t_cmp              o_res
);

    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W:0]   cand_right;
    logic [COORD_W:0]   kept_right;
    logic [COORD_W:0]   cand_bottom;
    logic [COORD_W:0]   kept_bottom;
    logic [COORD_W:0]   right;
    logic [COORD_W:0]   bottom;
    logic [COORD_W-1:0] n_iw;
    logic [COORD_W-1:0] n_ih;

    logic                r_v1, r_v2, r_v3, r_v4;
    logic [COORD_W-1:0]  r_iw;
    logic [COORD_W-1:0]  r_ih;
    logic [AREA_W:0]     r_sum1;
    logic [AREA_W-1:0]   r_inter2;
    logic [AREA_W:0]     r_sum2;
    logic [AREA_W-1:0]   r_inter3;
    logic [AREA_W:0]     r_union3;
    logic [AREA_W-1:0]   r_inter4;
    logic [AREA_W+THR_W:0] r_prod4;

    // Clipped overlap rectangle; the width can never exceed either box width.
    always_comb begin
        left        = (i_cand.x > i_kept.x) ? i_cand.x : i_kept.x;
        top         = (i_cand.y > i_kept.y) ? i_cand.y : i_kept.y;
        cand_right  = {1'b0, i_cand.x} + {1'b0, i_cand.w};
        kept_right  = {1'b0, i_kept.x} + {1'b0, i_kept.w};
        cand_bottom = {1'b0, i_cand.y} + {1'b0, i_cand.h};
        kept_bottom = {1'b0, i_kept.y} + {1'b0, i_kept.h};
        right       = (cand_right < kept_right) ? cand_right : kept_right;
        bottom      = (cand_bottom < kept_bottom) ? cand_bottom : kept_bottom;
        n_iw = '0;
        n_ih = '0;
        if ((right > {1'b0, left}) && (bottom > {1'b0, top})) begin
            n_iw = COORD_W'(right - {1'b0, left});
            n_ih = COORD_W'(bottom - {1'b0, top});
        end
    end

    // Valid chain follows the data through the four stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_rd_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Data stages: overlap size, intersection, union, threshold product.
    always_ff @(posedge i_clk) begin
        r_iw     <= n_iw;
        r_ih     <= n_ih;
        r_sum1   <= {1'b0, i_cand_area} + {1'b0, i_kept_area};
        r_inter2 <= AREA_W'(r_iw) * AREA_W'(r_ih);
        r_sum2   <= r_sum1;
        r_inter3 <= r_inter2;
        r_union3 <= r_sum2 - {1'b0, r_inter2};
        r_inter4 <= r_inter3;
        r_prod4  <= (AREA_W+THR_W+1)'(i_thr) * (AREA_W+THR_W+1)'(r_union3);
    end

    // Final compare is done on registered operands.
    always_comb begin
        o_res.busy  = r_v1 | r_v2 | r_v3 | r_v4;
        o_res.valid = r_v4;
        o_res.hit   = {2'b00, r_inter4, 8'd0} > r_prod4;
    end

endmodule

// ===== hdl/greedy_box_suppression.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy box suppression
// Non-maximum suppression by intersection over union for boxes that arrive
// sorted by falling score.
// ----------------------------------------------------------------------------
// Usage:
// Boxes come in on the input channel (i_in_valid / o_in_stall), one request
// per box. A set begins with i_start_of_set high, which empties the kept
// store and restarts the box numbering. One result request per box leaves on
// the output channel (o_out_valid / i_out_stall): its number in the set, a
// kept flag and a store overflow flag.
// Each box is read against every kept box from one synchronous memory, one
// entry per cycle, into a four stage compare pipeline. After the scan the
// pipeline drains, the result is loaded and the block goes back to idle,
// where it takes the next box. One box is in work at a time.
// The result sits in an output register, so the next box is taken while the
// result waits; a stalled receiver only holds the block when a second result
// is ready. Reset empties the store count and box counter and sets the
// threshold to 0.5; the store contents need no clearing. The user must write
// the threshold through i_cfg_we / i_cfg_data only while idle (not enforced).
// ----------------------------------------------------------------------------
module greedy_box_suppression
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT  = 64,
    parameter int MAX_BOXES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration
    input  logic               i_cfg_we,
    input  logic [THR_W-1:0]   i_cfg_data,
    // Box requests
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_start_of_set,
    input  logic [COORD_W-1:0] i_box_x,
    input  logic [COORD_W-1:0] i_box_y,
    input  logic [COORD_W-1:0] i_box_width,
    input  logic [COORD_W-1:0] i_box_height,
    // Result requests
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [NUM_W-1:0]   o_box_number,
    output logic               o_kept,
    output logic               o_store_overflow
);

    localparam int KW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam logic [CW-1:0] KEPT_FULL = CW'(MAX_KEPT);
    localparam logic [NUM_W-1:0] POS_CAP =
        (MAX_BOXES - 1 < 4095) ? NUM_W'(MAX_BOXES - 1) : NUM_MAX;
    localparam int MEM_W = $bits(t_box) + AREA_W;

    t_state              r_state, n_state;
    logic [THR_W-1:0]    r_thr;
    logic [CW-1:0]       r_total;
    logic [NUM_W-1:0]    r_pos;
    t_box                r_box;
    logic [AREA_W-1:0]   r_area;
    logic [NUM_W-1:0]    r_num;
    logic [CW-1:0]       r_rd_addr;
    logic                r_rd_valid;
    logic [MEM_W-1:0]    r_rd_data;
    logic                r_supp;
    logic                r_out_valid;
    logic [NUM_W-1:0]    r_out_num;
    logic                r_out_kept;
    logic                r_out_ovf;

    logic [MEM_W-1:0]    r_kept_mem [MAX_KEPT];

    logic                in_acc;
    logic                rd_issue;
    logic                out_load;
    logic                mem_we;
    logic                has_room;
    logic [NUM_W-1:0]    base_pos;
    t_box                kept_box;
    t_cmp                cmp;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign has_room = r_total < KEPT_FULL;
    assign base_pos = i_start_of_set ? '0 : r_pos;
    assign kept_box = t_box'(r_rd_data[MEM_W-1:AREA_W]);

    // Sequencer: accept, scan the store, drain the pipeline, deliver.
    always_comb begin
        n_state  = r_state;
        rd_issue = 1'b0;
        out_load = 1'b0;
        mem_we   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_addr < r_total) begin
                    rd_issue = 1'b1;
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_valid && !cmp.busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    mem_we   = !r_supp && has_room;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thr       <= THR_RESET;
            r_total     <= '0;
            r_pos       <= '0;
            r_rd_addr   <= '0;
            r_rd_valid  <= 1'b0;
            r_supp      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= rd_issue;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            // A new box restarts the scan and optionally the set.
            if (in_acc) begin
                r_rd_addr <= '0;
                r_supp    <= 1'b0;
                if (i_start_of_set) begin
                    r_total <= '0;
                end
                r_pos <= (base_pos < POS_CAP) ? base_pos + 1'b1 : base_pos;
            end else begin
                if (rd_issue) begin
                    r_rd_addr <= r_rd_addr + 1'b1;
                end
                if (cmp.valid && cmp.hit) begin
                    r_supp <= 1'b1;
                end
                if (mem_we) begin
                    r_total <= r_total + 1'b1;
                end
            end
            // Output register holds while the receiver stalls.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Box payload and result payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_box.x <= i_box_x;
            r_box.y <= i_box_y;
            r_box.w <= i_box_width;
            r_box.h <= i_box_height;
            r_area  <= AREA_W'(i_box_width) * AREA_W'(i_box_height);
            r_num   <= base_pos;
        end
        if (out_load) begin
            r_out_num  <= r_num;
            r_out_kept <= !r_supp && has_room;
            r_out_ovf  <= !r_supp && !has_room;
        end
    end

    // Kept store. Reads happen only during the scan and the single write
    // only at the end of an item, so the two never touch the same entry
    // in overlapping cycles.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_kept_mem[r_total[KW-1:0]] <= {r_box, r_area};
        end
        if (rd_issue) begin
            r_rd_data <= r_kept_mem[r_rd_addr[KW-1:0]];
        end
    end

    gbs_iou u_iou (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_valid  (r_rd_valid),
        .i_cand      (r_box),
        .i_cand_area (r_area),
        .i_kept      (kept_box),
        .i_kept_area (r_rd_data[AREA_W-1:0]),
        .i_thr       (r_thr),
        .o_res       (cmp)
    );

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_box_number     = r_out_num;
    assign o_kept           = r_out_kept;
    assign o_store_overflow = r_out_ovf;

endmodule

// ===== hdl/gbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy box suppression port checker
// Watches the ports of the suppression block and flags results or
// handshakes that the design should never produce.
// ----------------------------------------------------------------------------
module gbs_checker
    import gbs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [NUM_W-1:0]   o_box_number,
    input logic               o_kept,
    input logic               o_store_overflow
);

    // A box is either stored, overflowed or suppressed, never two at once.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_kept && o_store_overflow))
        else $error("kept and store overflow both set");

    // A stalled result holds its number and its valid.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_box_number))
        else $error("stalled result changed");

    // After taking a box the block works on it before taking another.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second box accepted without scan");

    // A fresh result only appears at the end of a scan.
    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a box in work");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_box_number     (o_box_number),
    .o_kept           (o_kept),
    .o_store_overflow (o_store_overflow)
);

// ===== tb/tb_greedy_box_suppression.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for greedy box suppression
// Sends boxes in sets and predicts every verdict with a behavioral model of
// the block. Covers fixed corner cases, threshold extremes, a full kept store,
// a long receiver hold-off and random clustered sets under changing idle
// patterns. Each result request is checked field by field.
// ----------------------------------------------------------------------------
module tb_greedy_box_suppression;
    import gbs_pkg::*;

    localparam int MAX_KEPT    = 64;
    localparam int MAX_BOXES   = 4096;
    localparam int SETTLE      = MAX_KEPT + 16;
    localparam int HOLD_CYCLES = 300;
    localparam int PRINT_LIMIT = 40;

    // One expected result request.
    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic             kept;
        logic             overflow;
    } t_verdict;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [THR_W-1:0]   i_cfg_data = THR_RESET;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_start_of_set = 1'b0;
    logic [COORD_W-1:0] i_box_x = '0;
    logic [COORD_W-1:0] i_box_y = '0;
    logic [COORD_W-1:0] i_box_width = '0;
    logic [COORD_W-1:0] i_box_height = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [NUM_W-1:0]   o_box_number;
    logic               o_kept;
    logic               o_store_overflow;

    // Behavioral copy of the suppression state.
    logic [THR_W-1:0]   iou_threshold = THR_RESET;
    t_box               kept_store [MAX_KEPT];
    logic [AREA_W-1:0]  kept_area_store [MAX_KEPT];
    int unsigned        kept_count = 0;
    logic [NUM_W-1:0]   next_box_number = '0;
    t_verdict           pending_verdicts [$];

    // Idle control and run statistics.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_granted = 0;
    int unsigned hold_left = 0;
    int unsigned mismatches = 0;
    int unsigned boxes_accepted = 0;
    int unsigned sets_started = 0;
    int unsigned kept_seen = 0;
    int unsigned overflow_seen = 0;
    int unsigned suppressed_seen = 0;

    greedy_box_suppression #(
        .MAX_KEPT  (MAX_KEPT),
        .MAX_BOXES (MAX_BOXES)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_start_of_set   (i_start_of_set),
        .i_box_x          (i_box_x),
        .i_box_y          (i_box_y),
        .i_box_width      (i_box_width),
        .i_box_height     (i_box_height),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_box_number     (o_box_number),
        .o_kept           (o_kept),
        .o_store_overflow (o_store_overflow)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Overlap area of two boxes, zero when they are disjoint or only touch.
    function automatic logic [63:0] overlap_area(input t_box a, input t_box b);
        logic [16:0] left, top, right, bottom, a_right, b_right, a_bottom, b_bottom;
        left     = (a.x > b.x) ? 17'(a.x) : 17'(b.x);
        top      = (a.y > b.y) ? 17'(a.y) : 17'(b.y);
        a_right  = 17'(a.x) + 17'(a.w);
        b_right  = 17'(b.x) + 17'(b.w);
        a_bottom = 17'(a.y) + 17'(a.h);
        b_bottom = 17'(b.y) + 17'(b.h);
        right    = (a_right < b_right) ? a_right : b_right;
        bottom   = (a_bottom < b_bottom) ? a_bottom : b_bottom;
        if (right <= left || bottom <= top) begin
            return 64'd0;
        end
        return 64'(right - left) * 64'(bottom - top);
    endfunction

    // Verdict for one box; updates the kept store as the block would.
    function automatic t_verdict judge_box(input logic sos, input t_box b);
        t_verdict    v;
        logic [63:0] area, inter, joint_area;
        logic        survive;
        int unsigned k;
        area = 64'(b.w) * 64'(b.h);
        if (sos) begin
            kept_count      = 0;
            next_box_number = '0;
        end
        v.number = next_box_number;
        if (next_box_number < NUM_MAX && next_box_number < NUM_W'(MAX_BOXES - 1)) begin
            next_box_number = next_box_number + 1'b1;
        end
        survive = 1'b1;
        for (k = 0; k < kept_count; k++) begin
            inter      = overlap_area(b, kept_store[k]);
            joint_area = area + 64'(kept_area_store[k]) - inter;
            if (inter * 64'd256 > 64'(iou_threshold) * joint_area) begin
                survive = 1'b0;
            end
        end
        v.kept     = 1'b0;
        v.overflow = 1'b0;
        if (survive) begin
            if (kept_count < MAX_KEPT) begin
                kept_store[kept_count]      = b;
                kept_area_store[kept_count] = area[AREA_W-1:0];
                kept_count++;
                v.kept = 1'b1;
            end else begin
                v.overflow = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic t_box box_at(input logic [15:0] x, y, w, h);
        t_box b;
        b.x = x;
        b.y = y;
        b.w = w;
        b.h = h;
        return b;
    endfunction

    // Random box: small coordinates near the origin, or the full field range.
    function automatic t_box random_box(input bit wide);
        t_box b;
        if (wide) begin
            b = box_at(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end else begin
            b = box_at(16'($urandom_range(0, 16'h3FFF)), 16'($urandom_range(0, 16'h3FFF)),
                       16'($urandom_range(0, 16'h0800)), 16'($urandom_range(0, 16'h0800)));
            if ($urandom_range(99) < 3) begin
                b.w = '0;
            end
        end
        return b;
    endfunction

    // Box scattered around a cluster center by up to a quarter of its size.
    function automatic t_box jitter_box(input t_box c);
        int qw, qh;
        qw = int'(c.w / 4) + 1;
        qh = int'(c.h / 4) + 1;
        return box_at(16'(int'(c.x) + int'($urandom_range(0, 2 * qw)) - qw),
                      16'(int'(c.y) + int'($urandom_range(0, 2 * qh)) - qh),
                      16'(int'(c.w) + int'($urandom_range(0, qw)) - qw / 2),
                      16'(int'(c.h) + int'($urandom_range(0, qh)) - qh / 2));
    endfunction

    // Offers one box request and records its verdict once it is accepted.
    task automatic send_box(input logic sos, input t_box b);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_start_of_set <= sos;
        i_box_x        <= b.x;
        i_box_y        <= b.y;
        i_box_width    <= b.w;
        i_box_height   <= b.h;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end
        pending_verdicts = {pending_verdicts, judge_box(sos, b)};
        boxes_accepted++;
        if (sos) begin
            sets_started++;
        end
    endtask

    // Stops sending and waits until every result has come out and the block is idle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        iou_threshold = value;
    endtask

    // Receiver stall: random idling, or a long hold-off when one is asked for.
    always @(posedge i_clk) begin
        if (hold_granted != hold_asked) begin
            hold_granted <= hold_asked;
            hold_left    <= HOLD_CYCLES;
            i_out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic compare_field(input string name, input int unsigned want, got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT) begin
                $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            end
        end
    endtask

    // Result check. Outputs are stable at the falling edge, so what is seen
    // here is what the next rising edge accepts.
    always @(negedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT) begin
                    $display("%0t ns: result expected none, actual number %0d kept %0b ovf %0b",
                             $time, o_box_number, o_kept, o_store_overflow);
                end
            end else begin
                want = pending_verdicts.pop_front();
                compare_field("box_number", want.number, o_box_number);
                compare_field("kept", want.kept, o_kept);
                compare_field("store_overflow", want.overflow, o_store_overflow);
            end
            if (o_kept) begin
                kept_seen++;
            end else if (o_store_overflow) begin
                overflow_seen++;
            end else begin
                suppressed_seen++;
            end
        end
    end

    // Corner cases at the reset threshold of one half.
    task automatic test_reset_threshold();
        send_idle_pct = 36;
        recv_idle_pct = 67;
        send_box(1'b1, box_at(16'h0100, 16'h0100, 16'h0100, 16'h0100));
        // Identical box, overlap ratio of one.
        send_box(1'b0, box_at(16'h0100, 16'h0100, 16'h0100, 16'h0100));
        // Shares only the right edge, so the intersection is empty.
        send_box(1'b0, box_at(16'h0200, 16'h0100, 16'h0100, 16'h0100));
        // Ratio exactly one half is kept; one unit more overlap is suppressed.
        send_box(1'b0, box_at(16'h1000, 16'h1000, 16'h0300, 16'h0100));
        send_box(1'b0, box_at(16'h1100, 16'h1000, 16'h0300, 16'h0100));
        send_box(1'b0, box_at(16'h10FF, 16'h1000, 16'h0300, 16'h0100));
        // Two empty boxes in one spot: zero union, never suppressed.
        send_box(1'b0, box_at(16'h2000, 16'h2000, 16'h0000, 16'h0000));
        send_box(1'b0, box_at(16'h2000, 16'h2000, 16'h0000, 16'h0000));
        // Largest fields: edges carry into the 17th bit.
        send_box(1'b1, box_at(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_box(1'b0, box_at(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_box(1'b0, box_at(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
        send_box(1'b0, box_at(16'hFFFE, 16'hFFFE, 16'h0002, 16'h0002));
        drain_results();
    endtask

    // Threshold of zero, one below one and one.
    task automatic test_threshold_extremes();
        write_threshold(9'd0);
        send_box(1'b1, box_at(16'h0400, 16'h0400, 16'h0200, 16'h0200));
        // A single unit of overlap already suppresses.
        send_box(1'b0, box_at(16'h05FF, 16'h05FF, 16'h0200, 16'h0200));
        send_box(1'b0, box_at(16'h0600, 16'h0400, 16'h0200, 16'h0200));
        drain_results();
        write_threshold(9'd256);
        send_box(1'b1, box_at(16'h0400, 16'h0400, 16'h0200, 16'h0200));
        send_box(1'b0, box_at(16'h0400, 16'h0400, 16'h0200, 16'h0200));
        send_box(1'b0, box_at(16'h0410, 16'h0400, 16'h0200, 16'h0200));
        drain_results();
        write_threshold(9'd255);
        send_box(1'b1, box_at(16'h0400, 16'h0400, 16'h0200, 16'h0200));
        send_box(1'b0, box_at(16'h0400, 16'h0400, 16'h0200, 16'h0200));
        send_box(1'b0, box_at(16'h0401, 16'h0400, 16'h0200, 16'h0200));
        drain_results();
    endtask

    // Clustered sets of random content, with a little noise and broken sets.
    task automatic test_random_sets(input int unsigned send_pct, recv_pct, box_goal);
        int unsigned sent, set_len, n_centers, i, k;
        t_box        centers [4];
        t_box        b;
        logic        sos;
        bit          wide;
        write_threshold(9'($urandom_range(0, 256)));
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < box_goal) begin
            set_len   = ($urandom_range(99) < 90) ? $urandom_range(1, 16)
                                                  : $urandom_range(17, 72);
            n_centers = $urandom_range(1, 4);
            wide      = ($urandom_range(99) < 15);
            for (i = 0; i < n_centers; i++) begin
                centers[i] = random_box(wide);
            end
            for (k = 0; k < set_len && sent < box_goal; k++) begin
                sos = (k == 0) ? ($urandom_range(99) < 95) : ($urandom_range(99) < 2);
                if ($urandom_range(99) < 85) begin
                    b = jitter_box(centers[$urandom_range(0, n_centers - 1)]);
                end else begin
                    b = random_box(1'b1);
                end
                send_box(sos, b);
                sent++;
            end
        end
        drain_results();
    endtask

    // Fill the kept store with disjoint boxes and go past it.
    task automatic test_store_overflow();
        int unsigned k;
        write_threshold(THR_RESET);
        send_idle_pct = 36;
        recv_idle_pct = 67;
        for (k = 0; k < MAX_KEPT + 6; k++) begin
            send_box(k == 0, box_at(16'((k % 16) * 16'h1000), 16'((k / 16) * 16'h1000),
                                    16'h0800, 16'h0800));
        end
        // Suppressed while full: no overflow flag.
        send_box(1'b0, box_at(16'h0000, 16'h0000, 16'h0800, 16'h0800));
        drain_results();
    endtask

    // Long receiver hold-off while boxes keep coming.
    task automatic test_backpressure();
        int unsigned k;
        t_box        center;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
        center = random_box(1'b0);
        for (k = 0; k < 24; k++) begin
            send_box(k == 0, jitter_box(center));
        end
        drain_results();
    endtask

    // Test sequence.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_threshold();
        test_threshold_extremes();
        test_random_sets(36, 67, 145);
        test_random_sets(67, 36, 145);
        test_random_sets(0, 0, 145);
        test_store_overflow();
        test_backpressure();
        $display("Covered %0d boxes in %0d sets: threshold extremes, full store, long hold-off,",
                 boxes_accepted, sets_started);
        $display("and random clusters; %0d kept, %0d suppressed, %0d dropped on a full store.",
                 kept_seen, suppressed_seen, overflow_seen);
        if (mismatches == 0) begin
            $display("greedy_box_suppression: match");
        end else begin
            $display("greedy_box_suppression: mismatch");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #20_000_000;
        $display("Timed out with %0d results outstanding.", pending_verdicts.size());
        $display("greedy_box_suppression: mismatch");
        $finish;
    end

endmodule
